FILE: hw/rtl/ffha_pkg.sv
// Shared types and codes of the first-fit heap allocator.
package ffha_pkg;

  // Operation codes carried by an input transaction.
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_DEFRAG = 2'd2,
    OP_INIT   = 2'd3
  } op_t;

  // One input transaction.
  typedef struct packed {
    op_t         op;
    logic [11:0] req_size;
    logic [11:0] in_addr;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic        status;
    logic [11:0] out_addr;
    logic [10:0] merged;
    logic [12:0] used_bytes;
    logic [12:0] free_bytes;
    logic [15:0] allocs_done;
    logic [15:0] frees_done;
  } out_item_t;

  // Width of the internal arithmetic on sizes and offsets.
  localparam int SUM_W = 18;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic init;
    logic adv;
    logic rd_nxt;
    logic cap;
    logic wr_tail;
    logic mark_alloc;
    logic mark_free;
    logic merge;
    logic finish;
    logic ok;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic req_zero;
    logic addr_zero;
    logic fit;
    logic split;
    logic match;
    logic past;
    logic used;
    logic at_end;
    logic nx_free;
  } sts_t;

endpackage

FILE: hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator over a byte heap with a header per block. One transaction is
// handled at a time. After reset the block writes the initial free block before it
// accepts input. Allocate, free and defragment walk the block chain through a header
// memory with one read port: each block visited is captured and then decided on, and
// a free block that defragment checks also reads its neighbor's header, merging it when
// it is free. A finished result waits in an output register; a new transaction is still
// accepted while that result is stalled, but its own result is held back until the
// previous one is taken.
module first_fit_heap_allocator #(
  parameter int HEAP_MAX     = 4096,
  parameter int HEADER_BYTES = 6,
  parameter int MIN_PAYLOAD  = 8,
  parameter int DEFAULT_HEAP = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [12:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffha_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffha_pkg::out_item_t out_data
);
  import ffha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  ffha_datapath #(
    .HEAP_MAX     (HEAP_MAX),
    .HEADER_BYTES (HEADER_BYTES),
    .MIN_PAYLOAD  (MIN_PAYLOAD),
    .DEFAULT_HEAP (DEFAULT_HEAP)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

endmodule

FILE: hw/rtl/ffha_datapath.sv
// Datapath of the allocator: header memory, walk pointer, statistics and result register.
module ffha_datapath #(
  parameter int HEAP_MAX     = 4096,
  parameter int HEADER_BYTES = 6,
  parameter int MIN_PAYLOAD  = 8,
  parameter int DEFAULT_HEAP = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [12:0]         cfg_wr_data,
  input  ffha_pkg::in_item_t  in_data,
  input  ffha_pkg::cmd_t      cmd,
  output ffha_pkg::sts_t      sts,
  output ffha_pkg::out_item_t out_data
);
  import ffha_pkg::*;

  localparam int OW = $clog2(HEAP_MAX + 1);
  localparam int AW = $clog2(HEAP_MAX);
  localparam int MW = OW + 1;
  localparam int SW = SUM_W;

  // Header memory, one entry per byte offset: used flag over block size.
  logic [MW-1:0] mem [HEAP_MAX];
  logic [MW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;

  logic [12:0]   heap_bytes;
  in_item_t      in_q;
  logic [OW-1:0] off;
  logic [OW-1:0] heap_len;
  logic [OW-1:0] cur_s;
  logic          cur_u;
  logic [10:0]   count;
  logic [12:0]   used_stat;
  logic [12:0]   free_stat;
  logic [15:0]   alloc_cnt;
  logic [15:0]   free_cnt;
  out_item_t     res;

  logic [SW-1:0] req_ext, rnd, tot_a, total, cur_ext, off_ext, len_ext;
  logic [SW-1:0] end_sum, nx, amount, merged_sz, hb_ext, n_a, n_b, n_c;
  logic [OW-1:0] nx_o;

  // Request sizing and block chain arithmetic.
  always_comb begin
    req_ext = SW'(in_q.req_size);
    rnd     = (req_ext + SW'(1)) & ~SW'(1);
    tot_a   = rnd + SW'(HEADER_BYTES);
    total   = (tot_a < SW'(MIN_PAYLOAD + HEADER_BYTES)) ?
              SW'(MIN_PAYLOAD + HEADER_BYTES) : tot_a;
    cur_ext = SW'(cur_s);
    off_ext = SW'(off);
    len_ext = SW'(heap_len);
    end_sum = off_ext + cur_ext;
    nx      = (cur_s == '0 || end_sum > len_ext) ? len_ext : end_sum;
    nx_o    = nx[OW-1:0];
    amount  = (cur_ext >= total + SW'(HEADER_BYTES + MIN_PAYLOAD)) ? total : cur_ext;
    merged_sz = cur_ext + SW'(rd_q[OW-1:0]);
    hb_ext  = SW'(heap_bytes);
    n_a     = (heap_bytes == '0) ? SW'(DEFAULT_HEAP) : hb_ext;
    n_b     = (n_a > SW'(HEAP_MAX)) ? SW'(HEAP_MAX) : n_a;
    n_c     = (n_b < SW'(HEADER_BYTES + MIN_PAYLOAD)) ?
              SW'(HEADER_BYTES + MIN_PAYLOAD) : n_b;
  end

  // Status toward the controller.
  always_comb begin
    sts.op        = in_q.op;
    sts.req_zero  = (in_q.req_size == '0);
    sts.addr_zero = (in_q.in_addr == '0);
    sts.fit       = !cur_u && (cur_ext >= total);
    sts.split     = (cur_ext >= total + SW'(HEADER_BYTES + MIN_PAYLOAD));
    sts.match     = (off_ext + SW'(HEADER_BYTES) == SW'(in_q.in_addr));
    sts.past      = (off_ext + SW'(HEADER_BYTES) > SW'(in_q.in_addr));
    sts.used      = cur_u;
    sts.at_end    = (nx >= len_ext);
    sts.nx_free   = !rd_q[OW];
  end

  // Memory write port select.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = off[AW-1:0];
    wr_data = {1'b0, cur_s};
    if (cmd.init) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = {1'b0, n_c[OW-1:0]};
    end else if (cmd.wr_tail) begin
      wr_en   = 1'b1;
      wr_addr = AW'(off_ext + total);
      wr_data = {1'b0, OW'(cur_ext - total)};
    end else if (cmd.mark_alloc) begin
      wr_en   = 1'b1;
      wr_data = {1'b1, amount[OW-1:0]};
    end else if (cmd.mark_free) begin
      wr_en   = 1'b1;
      wr_data = {1'b0, cur_s};
    end else if (cmd.merge) begin
      wr_en   = 1'b1;
      wr_data = {1'b0, merged_sz[OW-1:0]};
    end
    rd_addr = (cmd.adv || cmd.rd_nxt) ? nx_o[AW-1:0] : off[AW-1:0];
  end

  // Header memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_bytes <= '0;
    end else if (cfg_wr_en) begin
      heap_bytes <= cfg_wr_data;
    end
  end

  // Walk registers, statistics and counters.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      in_q  <= in_data;
      off   <= '0;
      count <= '0;
    end
    if (cmd.adv) begin
      off <= nx_o;
    end
    if (cmd.cap) begin
      cur_s <= rd_q[OW-1:0];
      cur_u <= rd_q[OW];
    end
    if (cmd.merge) begin
      cur_s <= merged_sz[OW-1:0];
      count <= count + 11'd1;
    end
    if (cmd.init) begin
      heap_len  <= n_c[OW-1:0];
      used_stat <= 13'(HEADER_BYTES);
      free_stat <= 13'(n_c - SW'(HEADER_BYTES));
      alloc_cnt <= '0;
      free_cnt  <= '0;
    end
    if (cmd.mark_alloc) begin
      used_stat <= used_stat + amount[12:0];
      free_stat <= free_stat - amount[12:0];
      alloc_cnt <= alloc_cnt + 16'd1;
    end
    if (cmd.mark_free) begin
      used_stat <= used_stat - 13'(cur_ext);
      free_stat <= free_stat + 13'(cur_ext);
      free_cnt  <= free_cnt + 16'd1;
    end
  end

  // Result register, loaded when the controller hands over a finished transaction.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.status      <= !cmd.ok;
      res.out_addr    <= (cmd.ok && in_q.op == OP_ALLOC) ?
                         12'(off_ext + SW'(HEADER_BYTES)) : 12'd0;
      res.merged      <= (in_q.op == OP_DEFRAG) ? count : 11'd0;
      res.used_bytes  <= used_stat;
      res.free_bytes  <= free_stat;
      res.allocs_done <= alloc_cnt;
      res.frees_done  <= free_cnt;
    end
  end

  assign out_data = res;

endmodule

FILE: hw/rtl/ffha_ctrl.sv
// Controller state machine that sequences the block chain walk.
module ffha_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ffha_pkg::sts_t sts,
  output ffha_pkg::cmd_t cmd
);
  import ffha_pkg::*;

  typedef enum logic [8:0] {
    S_RINIT = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DISP  = 9'b000000100,
    S_CAP   = 9'b000001000,
    S_DEC   = 9'b000010000,
    S_NCAP  = 9'b000100000,
    S_NDEC  = 9'b001000000,
    S_MARK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   ok, ok_next;
  logic   out_valid_next;

  assign in_stall = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    ok_next    = ok;
    cmd        = '0;
    cmd.ok     = ok;
    unique case (state)
      S_RINIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        ok_next    = 1'b0;
        state_next = S_CAP;
        if (sts.op == OP_INIT) begin
          cmd.init   = 1'b1;
          ok_next    = 1'b1;
          state_next = S_DONE;
        end else if ((sts.op == OP_ALLOC && sts.req_zero) ||
                     (sts.op == OP_FREE && sts.addr_zero)) begin
          state_next = S_DONE;
        end
      end
      S_CAP: begin
        cmd.cap    = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        case (sts.op)
          OP_ALLOC: begin
            if (sts.fit) begin
              cmd.wr_tail = sts.split;
              state_next  = S_MARK;
            end else if (sts.at_end) begin
              state_next = S_DONE;
            end else begin
              cmd.adv    = 1'b1;
              state_next = S_CAP;
            end
          end
          OP_FREE: begin
            if (sts.match) begin
              cmd.mark_free = sts.used;
              ok_next       = sts.used;
              state_next    = S_DONE;
            end else if (sts.past || sts.at_end) begin
              state_next = S_DONE;
            end else begin
              cmd.adv    = 1'b1;
              state_next = S_CAP;
            end
          end
          default: begin
            if (sts.at_end) begin
              ok_next    = 1'b1;
              state_next = S_DONE;
            end else if (!sts.used) begin
              cmd.rd_nxt = 1'b1;
              state_next = S_NCAP;
            end else begin
              cmd.adv    = 1'b1;
              state_next = S_CAP;
            end
          end
        endcase
      end
      S_NCAP: begin
        // Keep the next block's header on the read port for the decision cycle.
        cmd.rd_nxt = 1'b1;
        state_next = S_NDEC;
      end
      S_NDEC: begin
        if (sts.nx_free) begin
          cmd.merge  = 1'b1;
          state_next = S_DEC;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_CAP;
        end
      end
      S_MARK: begin
        cmd.mark_alloc = 1'b1;
        ok_next        = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output valid flag of the result register.
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (cmd.finish) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RINIT;
      ok        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ok        <= ok_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: hw/rtl/ffha_checker.sv
// Port-level checker of the allocator and its bind statement.
module ffha_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ffha_pkg::out_item_t out_data
);
  import ffha_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The block is busy right after it takes a transaction.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // A failed operation never returns an address.
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.out_addr == 12'd0)
    else $error("failed operation carries an address");

  // Merges are only reported by a defragment, which never returns an address.
  a_merge: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.merged != 11'd0 |->
      !out_data.status && out_data.out_addr == 12'd0)
    else $error("merge count on a non-defragment result");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: sim/tb_first_fit_heap_allocator.sv
// Self-checking testbench of the first-fit heap allocator with its own predictor.
module tb_first_fit_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int HEAP_MAX     = 4096;
  localparam int HEADER_BYTES = 6;
  localparam int MIN_PAYLOAD  = 8;
  localparam int DEFAULT_HEAP = 4096;
  localparam int MIN_BLOCK    = HEADER_BYTES + MIN_PAYLOAD;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [12:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  first_fit_heap_allocator u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: block headers by byte offset, statistics and counters.
  logic [15:0] hdr_size [HEAP_MAX];
  logic        hdr_used [HEAP_MAX];
  int          heap_len;
  logic [12:0] cfg_heap;
  logic [12:0] used_stat, free_stat;
  logic [15:0] alloc_cnt, free_cnt;

  in_item_t  pending_q [$];
  out_item_t expected_q [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        live_addrs [$];

  function automatic int next_block(int off);
    int s;
    s = hdr_size[off];
    if (s == 0 || off + s > heap_len) return heap_len;
    return off + s;
  endfunction

  function automatic void heap_rebuild();
    int n;
    n = cfg_heap;
    if (n == 0) n = DEFAULT_HEAP;
    if (n > HEAP_MAX) n = HEAP_MAX;
    if (n < MIN_BLOCK) n = MIN_BLOCK;
    heap_len = n;
    for (int i = 0; i < HEAP_MAX; i++) begin
      hdr_size[i] = '0;
      hdr_used[i] = 1'b0;
    end
    hdr_size[0] = n[15:0];
    used_stat = 13'(HEADER_BYTES);
    free_stat = 13'(n - HEADER_BYTES);
    alloc_cnt = '0;
    free_cnt = '0;
  endfunction

  // Computes the result of one operation and updates the predicted heap.
  function automatic out_item_t heap_apply(in_item_t it);
    out_item_t r;
    int total, off, s, nx, cnt;
    r = '0;
    r.status = 1'b1;
    case (it.op)
      OP_ALLOC: begin
        if (it.req_size != 0) begin
          total = ((int'(it.req_size) + 1) & ~1) + HEADER_BYTES;
          if (total < MIN_BLOCK) total = MIN_BLOCK;
          off = 0;
          while (off < heap_len) begin
            s = hdr_size[off];
            if (!hdr_used[off] && s >= total) begin
              if (s >= total + MIN_BLOCK) begin
                hdr_size[off + total] = 16'(s - total);
                hdr_used[off + total] = 1'b0;
                s = total;
              end
              hdr_size[off] = 16'(s);
              hdr_used[off] = 1'b1;
              used_stat = used_stat + 13'(s);
              free_stat = free_stat - 13'(s);
              alloc_cnt = alloc_cnt + 1'b1;
              r.status = 1'b0;
              r.out_addr = 12'(off + HEADER_BYTES);
              break;
            end
            off = next_block(off);
          end
        end
      end
      OP_FREE: begin
        if (it.in_addr != 0) begin
          off = 0;
          while (off < heap_len) begin
            if (off + HEADER_BYTES == int'(it.in_addr)) begin
              if (hdr_used[off]) begin
                s = hdr_size[off];
                hdr_used[off] = 1'b0;
                used_stat = used_stat - 13'(s);
                free_stat = free_stat + 13'(s);
                free_cnt = free_cnt + 1'b1;
                r.status = 1'b0;
              end
              break;
            end
            if (off + HEADER_BYTES > int'(it.in_addr)) break;
            off = next_block(off);
          end
        end
      end
      OP_DEFRAG: begin
        off = 0;
        cnt = 0;
        while (off < heap_len) begin
          nx = next_block(off);
          if (nx < heap_len && !hdr_used[off] && !hdr_used[nx]) begin
            hdr_size[off] = hdr_size[off] + hdr_size[nx];
            cnt++;
          end else begin
            off = nx;
          end
        end
        r.merged = 11'(cnt);
        r.status = 1'b0;
      end
      default: begin
        heap_rebuild();
        r.status = 1'b0;
      end
    endcase
    r.used_bytes = used_stat;
    r.free_bytes = free_stat;
    r.allocs_done = alloc_cnt;
    r.frees_done = free_cnt;
    return r;
  endfunction

  // Set when no transaction was taken at the last rising edge.
  logic in_stall_q = 1'b1;

  // Driver: presents queued transactions, idling at random.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall_q) begin
        // Held transaction still waiting; keep it.
      end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Acceptance flag sampled at the rising edge, used by the driver.
  always @(posedge clk) begin
    in_stall_q <= !(in_valid && !in_stall);
  end

  // Monitor: predicts on accepted input and checks accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_q.push_back(heap_apply(in_data));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          check_result(expected_q.pop_front(), out_data);
        end
      end
    end
  end

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_result(out_item_t e, out_item_t g);
    if (g.status !== e.status)
      report_mismatch($sformatf("status %0d, want %0d", g.status, e.status));
    if (g.out_addr !== e.out_addr)
      report_mismatch($sformatf("out_addr %0d, want %0d", g.out_addr, e.out_addr));
    if (g.merged !== e.merged)
      report_mismatch($sformatf("merged %0d, want %0d", g.merged, e.merged));
    if (g.used_bytes !== e.used_bytes)
      report_mismatch($sformatf("used_bytes %0d, want %0d", g.used_bytes, e.used_bytes));
    if (g.free_bytes !== e.free_bytes)
      report_mismatch($sformatf("free_bytes %0d, want %0d", g.free_bytes, e.free_bytes));
    if (g.allocs_done !== e.allocs_done)
      report_mismatch($sformatf("allocs_done %0d, want %0d", g.allocs_done, e.allocs_done));
    if (g.frees_done !== e.frees_done)
      report_mismatch($sformatf("frees_done %0d, want %0d", g.frees_done, e.frees_done));
  endtask

  function automatic in_item_t make_item(op_t op, int req, int addr);
    in_item_t it;
    it.op = op;
    it.req_size = 12'(req);
    it.in_addr = 12'(addr);
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Writes the heap size register while the block is idle, then reinitializes.
  task automatic set_heap(logic [12:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_heap = v;
    pending_q.push_back(make_item(OP_INIT, 0, 0));
  endtask

  // Random traffic, mostly allocations and frees.
  task automatic random_items(int n);
    int k, a;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) begin
        a = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 120);
        pending_q.push_back(make_item(OP_ALLOC, a, $urandom_range(4095)));
      end else if (k < 80) begin
        // Free a plausible block start, sometimes an odd or random address.
        a = $urandom_range(4095);
        if ($urandom_range(3) != 0) a = HEADER_BYTES + 2 * $urandom_range(100);
        pending_q.push_back(make_item(OP_FREE, $urandom_range(4095), a));
      end else if (k < 96) begin
        pending_q.push_back(make_item(OP_DEFRAG, $urandom_range(4095), $urandom_range(4095)));
      end else begin
        pending_q.push_back(make_item(OP_INIT, $urandom_range(4095), $urandom_range(4095)));
      end
      if (pending_q.size() > 50) while (pending_q.size() > 10) @(posedge clk);
    end
  endtask

  initial begin
    cfg_heap = '0;
    heap_rebuild();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every operation and the special cases.
    pending_q.push_back(make_item(OP_ALLOC, 0, 0));
    pending_q.push_back(make_item(OP_ALLOC, 1, 4095));
    pending_q.push_back(make_item(OP_ALLOC, 7, 0));
    pending_q.push_back(make_item(OP_ALLOC, 9, 0));
    pending_q.push_back(make_item(OP_FREE, 0, 0));
    pending_q.push_back(make_item(OP_FREE, 0, 7));
    pending_q.push_back(make_item(OP_FREE, 4095, 6));
    pending_q.push_back(make_item(OP_FREE, 0, 6));
    pending_q.push_back(make_item(OP_FREE, 0, 4095));
    pending_q.push_back(make_item(OP_DEFRAG, 0, 0));
    pending_q.push_back(make_item(OP_DEFRAG, 0, 0));
    pending_q.push_back(make_item(OP_ALLOC, 4095, 0));
    pending_q.push_back(make_item(OP_ALLOC, 4084, 0));
    pending_q.push_back(make_item(OP_ALLOC, 4, 0));
    pending_q.push_back(make_item(OP_FREE, 0, 6));
    pending_q.push_back(make_item(OP_INIT, 4095, 4095));

    // The sender holds off here until every result is back.
    wait_drained();

    // Random phases under several heap sizes and idling profiles.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_heap(13'd0);
        1: set_heap(13'd4096);
        2: set_heap(13'd1);
        3: set_heap(13'd8191);
        4: set_heap(13'd14);
        5: set_heap(13'd300);
        6: set_heap(13'd5000);
        default: set_heap(13'd1024);
      endcase
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 15 : 50) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 15 : 50) : 0;
      random_items(250);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();

    $display("Ran directed and random allocate, free, defragment and reinitialize traffic");
    $display("over eight heap sizes with idle and stall phases: %0d results checked.",
             results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_datapath.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator.sv
hw/rtl/ffha_checker.sv
sim/tb_first_fit_heap_allocator.sv
